### src/gss_pkg.sv
// gss_pkg: shared constants, widths and types of the gamepad stick shaper
// no dependencies; used by gss_lane, gss_merge and gamepad_stick_shaper_unit
package gss_pkg;

    // fixed point fraction bits, percent units
    localparam int FRACTION_BITS = 16;
    // negate the right stick vertical output
    localparam logic INVERT_RIGHT_Y = 1'b0;

    localparam int VAL_W     = 8;
    localparam int CFG_W     = 7;
    localparam int NUM_CFG   = 8;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LT_THR = 3'd0,
        REG_RT_THR = 3'd1,
        REG_L_DEAD = 3'd2,
        REG_L_AXIS = 3'd3,
        REG_L_DIAG = 3'd4,
        REG_R_DEAD = 3'd5,
        REG_R_AXIS = 3'd6,
        REG_R_DIAG = 3'd7
    } cfg_idx_t;

    localparam logic [CFG_W-1:0] PCT_FULL  = 7'd100;
    localparam logic [CFG_W-1:0] DEAD_MAX  = 7'd99;
    localparam logic [CFG_W-1:0] RANGE_MIN = 7'd1;
    localparam logic [VAL_W-1:0] OUT_FULL  = 8'd100;

    localparam logic [CFG_W-1:0] CFG_RESET [0:NUM_CFG-1] =
        '{7'd0, 7'd0, 7'd0, 7'd100, 7'd100, 7'd0, 7'd100, 7'd100};

    // datapath widths
    localparam int SQ_W    = 16;                      // x*x + y*y
    localparam int ROOT_W  = SQ_W / 2 + FRACTION_BITS; // magnitude
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int DIAG_W  = FRACTION_BITS + 1;       // diagonality
    localparam int DV_W    = VAL_W + FRACTION_BITS;
    localparam int PROD_W  = DIAG_W + 9;
    localparam int SAT_W   = FRACTION_BITS + CFG_W;
    localparam int TN_W    = ROOT_W + FRACTION_BITS;
    localparam int TQ_W    = FRACTION_BITS + 1;
    localparam int PX_W    = VAL_W + TQ_W;
    localparam int SN_W    = FRACTION_BITS + 17;
    localparam int QW      = 8;

    // stage map of one lane
    localparam int SQRT_STEPS   = ROOT_W;
    localparam int DIAG_STEPS   = DIAG_W;
    localparam int ST_SAT_MUL   = SQRT_STEPS;
    localparam int ST_SAT_ADD   = ST_SAT_MUL + 1;
    localparam int ST_T_PREP    = ST_SAT_ADD + 1;
    localparam int ST_T_DIV     = ST_T_PREP + 1;
    localparam int ST_SCALE_MUL = ST_T_DIV + TQ_W;
    localparam int ST_SCALE_NUM = ST_SCALE_MUL + 1;
    localparam int ST_Q_DIV     = ST_SCALE_NUM + 1;
    localparam int NSTEP        = ST_Q_DIV + QW;

    typedef struct packed {
        logic [CFG_W-1:0] dead;
        logic [CFG_W-1:0] axis;
        logic [CFG_W-1:0] diag;
    } stick_cfg_t;

    typedef struct packed {
        logic [VAL_W-1:0] x;
        logic [VAL_W-1:0] y;
    } stick_out_t;

    typedef struct packed {
        stick_out_t       left;
        stick_out_t       right;
        logic [VAL_W-1:0] lt;
        logic [VAL_W-1:0] rt;
    } report_t;

endpackage

### src/gss_lane.sv
// gss_lane: radial deadzone and range scaling of one stick, fully pipelined
// depends on gss_pkg
module gss_lane (
    input  logic                          clk,
    input  logic                          adv,
    input  logic [gss_pkg::VAL_W-1:0]     x_in,
    input  logic [gss_pkg::VAL_W-1:0]     y_in,
    input  gss_pkg::stick_cfg_t           cfg,
    output gss_pkg::stick_out_t           result
);

    localparam int FB = gss_pkg::FRACTION_BITS;

    typedef struct packed {
        logic [7:0]                     x;
        logic [7:0]                     y;
        logic                           neutral;
        logic                           zero_out;
        logic [6:0]                     dead;
        logic [6:0]                     axr;
        logic [6:0]                     dgr;
        logic [7:0]                     ux;
        logic [7:0]                     uy;
        logic [7:0]                     peak;
        logic [gss_pkg::RAD_W-1:0]      sq_rad;
        logic [gss_pkg::ROOT_W:0]       sq_rem;
        logic [gss_pkg::ROOT_W-1:0]     sq_root;
        logic [gss_pkg::DV_W-1:0]       dv_rem;
        logic [gss_pkg::DIAG_W-1:0]     diag;
        logic [gss_pkg::PROD_W-1:0]     sat_prod;
        logic [gss_pkg::SAT_W-1:0]      sat;
        logic                           magle;
        logic                           t_ovf;
        logic [gss_pkg::TN_W-1:0]       t_rem;
        logic [gss_pkg::SAT_W-1:0]      t_den;
        logic [gss_pkg::TQ_W-1:0]       t_q;
        logic [gss_pkg::PX_W-1:0]       px;
        logic [gss_pkg::PX_W-1:0]       py;
        logic [gss_pkg::SN_W-1:0]       nx;
        logic [gss_pkg::SN_W-1:0]       ny;
        logic [gss_pkg::SN_W-1:0]       qden;
        logic [gss_pkg::QW-1:0]         qx;
        logic [gss_pkg::QW-1:0]         qy;
    } lane_pipe_t;

    function automatic lane_pipe_t lane_prep(input logic [7:0] x, input logic [7:0] y,
                                             input gss_pkg::stick_cfg_t c);
        lane_pipe_t n;
        logic [7:0]  ax;
        logic [7:0]  ay;
        logic [15:0] sq;
        logic [6:0]  dz;
        logic [13:0] dd;
        n = '0;
        ax = x[7] ? 8'(-x) : x;
        ay = y[7] ? 8'(-y) : y;
        sq = 16'(ax) * 16'(ax) + 16'(ay) * 16'(ay);
        dz = (c.dead > gss_pkg::DEAD_MAX) ? gss_pkg::DEAD_MAX : c.dead;
        dd = 14'(dz) * 14'(dz);
        n.x        = x;
        n.y        = y;
        n.neutral  = (c.dead == '0) && (c.axis == gss_pkg::PCT_FULL)
                     && (c.diag == gss_pkg::PCT_FULL);
        n.zero_out = (sq == '0) || (sq <= 16'(dd));
        n.dead     = dz;
        n.axr      = (c.axis < gss_pkg::RANGE_MIN) ? gss_pkg::RANGE_MIN :
                     (c.axis > gss_pkg::PCT_FULL) ? gss_pkg::PCT_FULL : c.axis;
        n.dgr      = (c.diag < gss_pkg::RANGE_MIN) ? gss_pkg::RANGE_MIN :
                     (c.diag > gss_pkg::PCT_FULL) ? gss_pkg::PCT_FULL : c.diag;
        n.ux       = ax;
        n.uy       = ay;
        n.peak     = (ax > ay) ? ax : ay;
        n.sq_rad   = {sq, {(2 * FB){1'b0}}};
        n.dv_rem   = {((ax > ay) ? ay : ax), {FB{1'b0}}};
        return n;
    endfunction

    function automatic lane_pipe_t lane_step(input int k, input lane_pipe_t s);
        lane_pipe_t                   n;
        logic [gss_pkg::ROOT_W+2:0]   rem2;
        logic [gss_pkg::ROOT_W+2:0]   trial;
        logic [gss_pkg::DV_W-1:0]     dsh;
        logic [gss_pkg::TN_W-1:0]     tsh;
        logic [gss_pkg::SN_W-1:0]     qsh;
        logic signed [gss_pkg::PROD_W-1:0] sat_s;
        logic signed [gss_pkg::PROD_W-1:0] dead_s;
        logic signed [7:0]            dlt;
        logic [gss_pkg::ROOT_W-1:0]   dead_fx;
        logic [gss_pkg::SAT_W-1:0]    den;
        logic [gss_pkg::TQ_W-1:0]     t;
        n = s;
        if (k < gss_pkg::SQRT_STEPS) begin
            // one root bit per stage
            rem2  = {s.sq_rem, s.sq_rad[gss_pkg::RAD_W-1 -: 2]};
            trial = (gss_pkg::ROOT_W + 3)'({s.sq_root, 2'b01});
            n.sq_rad = s.sq_rad << 2;
            if (rem2 >= trial) begin
                n.sq_rem  = (gss_pkg::ROOT_W + 1)'(rem2 - trial);
                n.sq_root = {s.sq_root[gss_pkg::ROOT_W-2:0], 1'b1};
            end
            else begin
                n.sq_rem  = (gss_pkg::ROOT_W + 1)'(rem2);
                n.sq_root = {s.sq_root[gss_pkg::ROOT_W-2:0], 1'b0};
            end
            // diagonality quotient, one bit per stage alongside
            if (k < gss_pkg::DIAG_STEPS) begin
                dsh = gss_pkg::DV_W'(s.peak) << (FB - k);
                if (s.dv_rem >= dsh) begin
                    n.dv_rem = s.dv_rem - dsh;
                    n.diag   = {s.diag[gss_pkg::DIAG_W-2:0], 1'b1};
                end
                else begin
                    n.diag   = {s.diag[gss_pkg::DIAG_W-2:0], 1'b0};
                end
            end
        end
        else if (k == gss_pkg::ST_SAT_MUL) begin
            dlt = $signed({1'b0, s.dgr}) - $signed({1'b0, s.axr});
            n.sat_prod = gss_pkg::PROD_W'($signed(gss_pkg::PROD_W'(dlt))
                         * $signed(gss_pkg::PROD_W'(s.diag)));
        end
        else if (k == gss_pkg::ST_SAT_ADD) begin
            sat_s  = $signed(gss_pkg::PROD_W'({s.axr, {FB{1'b0}}}))
                     + $signed(s.sat_prod);
            dead_s = $signed(gss_pkg::PROD_W'({s.dead, {FB{1'b0}}}));
            if (sat_s <= dead_s)
                n.sat = {s.dead, {FB{1'b0}}} + {7'd1, {FB{1'b0}}};
            else
                n.sat = gss_pkg::SAT_W'(sat_s);
        end
        else if (k == gss_pkg::ST_T_PREP) begin
            dead_fx = gss_pkg::ROOT_W'({s.dead, {FB{1'b0}}});
            den     = s.sat - {s.dead, {FB{1'b0}}};
            n.magle = (s.sq_root <= dead_fx);
            n.t_rem = {s.sq_root - dead_fx, {FB{1'b0}}};
            n.t_den = den;
            n.t_ovf = (n.t_rem >= (gss_pkg::TN_W'(den) << (FB + 1)));
            n.t_q   = '0;
        end
        else if (k < gss_pkg::ST_SCALE_MUL) begin
            tsh = gss_pkg::TN_W'(s.t_den) << (FB - (k - gss_pkg::ST_T_DIV));
            if (s.t_rem >= tsh) begin
                n.t_rem = s.t_rem - tsh;
                n.t_q   = {s.t_q[gss_pkg::TQ_W-2:0], 1'b1};
            end
            else begin
                n.t_q   = {s.t_q[gss_pkg::TQ_W-2:0], 1'b0};
            end
        end
        else if (k == gss_pkg::ST_SCALE_MUL) begin
            if (s.magle)
                t = '0;
            else if (s.t_ovf || (s.t_q > {1'b1, {FB{1'b0}}}))
                t = {1'b1, {FB{1'b0}}};
            else
                t = s.t_q;
            n.px = gss_pkg::PX_W'(s.ux) * gss_pkg::PX_W'(t);
            n.py = gss_pkg::PX_W'(s.uy) * gss_pkg::PX_W'(t);
        end
        else if (k == gss_pkg::ST_SCALE_NUM) begin
            // 2*c*t*100 + peak*2^F over peak*2^(F+1): rounded half up
            n.nx   = ((gss_pkg::SN_W'(s.px) * gss_pkg::SN_W'(gss_pkg::OUT_FULL)) << 1)
                     + (gss_pkg::SN_W'(s.peak) << FB);
            n.ny   = ((gss_pkg::SN_W'(s.py) * gss_pkg::SN_W'(gss_pkg::OUT_FULL)) << 1)
                     + (gss_pkg::SN_W'(s.peak) << FB);
            n.qden = gss_pkg::SN_W'(s.peak) << (FB + 1);
            n.qx   = '0;
            n.qy   = '0;
        end
        else begin
            qsh = s.qden << (gss_pkg::QW - 1 - (k - gss_pkg::ST_Q_DIV));
            if (s.nx >= qsh) begin
                n.nx = s.nx - qsh;
                n.qx = {s.qx[gss_pkg::QW-2:0], 1'b1};
            end
            else begin
                n.qx = {s.qx[gss_pkg::QW-2:0], 1'b0};
            end
            if (s.ny >= qsh) begin
                n.ny = s.ny - qsh;
                n.qy = {s.qy[gss_pkg::QW-2:0], 1'b1};
            end
            else begin
                n.qy = {s.qy[gss_pkg::QW-2:0], 1'b0};
            end
        end
        return n;
    endfunction

    lane_pipe_t pipe_reg  [0:gss_pkg::NSTEP];
    lane_pipe_t pipe_next [0:gss_pkg::NSTEP];

    assign pipe_next[0] = lane_prep(x_in, y_in, cfg);

    always_ff @(posedge clk)
    begin
        if (adv)
            pipe_reg[0] <= pipe_next[0];
    end

    for (genvar k = 0; k < gss_pkg::NSTEP; k++)
    begin : g_stage
        assign pipe_next[k+1] = lane_step(k, pipe_reg[k]);

        always_ff @(posedge clk)
        begin
            if (adv)
                pipe_reg[k+1] <= pipe_next[k+1];
        end
    end

    // sign, clamp and bypass on the last stage
    logic [7:0] vx;
    logic [7:0] vy;
    lane_pipe_t last;

    assign last = pipe_reg[gss_pkg::NSTEP];
    assign vx   = (last.qx > gss_pkg::OUT_FULL) ? gss_pkg::OUT_FULL : last.qx;
    assign vy   = (last.qy > gss_pkg::OUT_FULL) ? gss_pkg::OUT_FULL : last.qy;

    always_comb
    begin
        if (last.neutral) begin
            result.x = last.x;
            result.y = last.y;
        end
        else if (last.zero_out) begin
            result.x = '0;
            result.y = '0;
        end
        else begin
            result.x = last.x[7] ? 8'(-vx) : vx;
            result.y = last.y[7] ? 8'(-vy) : vy;
        end
    end

endmodule

### src/gss_merge.sv
// gss_merge: joins both stick lanes and the triggers into one report item
// and holds it in a two-entry output queue; depends on gss_pkg
module gss_merge (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  gss_pkg::stick_out_t       left,
    input  gss_pkg::stick_out_t       right,
    input  logic [gss_pkg::VAL_W-1:0] lt,
    input  logic [gss_pkg::VAL_W-1:0] rt,
    output logic                      ready,
    output logic                      out_valid,
    input  logic                      out_stall,
    output gss_pkg::report_t          report
);

    localparam logic [1:0] DEPTH = 2'd2;

    gss_pkg::report_t merged;
    gss_pkg::report_t slot_reg [0:1];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    logic             pop;

    always_comb
    begin
        merged.left    = left;
        merged.right.x = right.x;
        merged.right.y = gss_pkg::INVERT_RIGHT_Y ? 8'(-right.y) : right.y;
        merged.lt      = lt;
        merged.rt      = rt;
    end

    // ready comes from the count alone, so the output stall has no combinational path to the input
    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && !out_stall;
    assign ready     = (cnt_reg != DEPTH);
    assign report    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= merged;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH)
        else $error("output queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ready)
        else $error("item pushed into full output queue");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push && cnt_reg == 2'd1) |=> !out_valid)
        else $error("output valid after last item left");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("output queue count did not follow push");

endmodule

### src/gamepad_stick_shaper_unit.sv
// gamepad_stick_shaper_unit: top level of the controller report shaper
// depends on gss_pkg, gss_lane and gss_merge
//
// takes one report item per cycle while in_stall is low (two sticks, two
// triggers, percent) and returns one shaped item for each; the per-stick
// pipeline registers the prepared input, then has one stage per bit of the
// magnitude square root, three to form the saturation radius and the
// fraction setup, one per bit of the range fraction divide, two for scaling,
// eight for the final rounding divide and one into the output queue, with
// the diagonality divide riding alongside the root stages; both sticks run
// in two identical lanes and a two-entry output queue lets new items enter
// while a result waits to be taken; the input stalls only once that queue
// is full and the pipe tail holds an item; triggers are thresholded on
// entry and travel with the item; configuration is taken through a plain
// write port and is sampled when an item enters, so it should only change
// while the block is empty
module gamepad_stick_shaper_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [gss_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [gss_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [gss_pkg::VAL_W-1:0]      left_x_in,
    input  logic signed [gss_pkg::VAL_W-1:0]      left_y_in,
    input  logic signed [gss_pkg::VAL_W-1:0]      right_x_in,
    input  logic signed [gss_pkg::VAL_W-1:0]      right_y_in,
    input  logic signed [gss_pkg::VAL_W-1:0]      left_trigger_in,
    input  logic signed [gss_pkg::VAL_W-1:0]      right_trigger_in,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [gss_pkg::VAL_W-1:0]      left_x_out,
    output logic signed [gss_pkg::VAL_W-1:0]      left_y_out,
    output logic signed [gss_pkg::VAL_W-1:0]      right_x_out,
    output logic signed [gss_pkg::VAL_W-1:0]      right_y_out,
    output logic signed [gss_pkg::VAL_W-1:0]      left_trigger_out,
    output logic signed [gss_pkg::VAL_W-1:0]      right_trigger_out
);

    typedef struct packed {
        logic [gss_pkg::VAL_W-1:0] lt;
        logic [gss_pkg::VAL_W-1:0] rt;
    } trig_t;

    // zero threshold passes the value through, otherwise 100 above it else 0
    function automatic logic [7:0] trig_shape(input logic [7:0] v,
                                              input logic [6:0] thr);
        logic [7:0] r;
        if (thr == '0)
            r = v;
        else if ($signed(v) > $signed({1'b0, thr}))
            r = gss_pkg::OUT_FULL;
        else
            r = '0;
        return r;
    endfunction

    // configuration registers
    logic [gss_pkg::CFG_W-1:0] cfg_reg [0:gss_pkg::NUM_CFG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= gss_pkg::CFG_RESET;
        else if (cfg_we)
            cfg_reg[cfg_index] <= cfg_data;
    end

    gss_pkg::stick_cfg_t left_cfg;
    gss_pkg::stick_cfg_t right_cfg;

    assign left_cfg.dead  = cfg_reg[gss_pkg::REG_L_DEAD];
    assign left_cfg.axis  = cfg_reg[gss_pkg::REG_L_AXIS];
    assign left_cfg.diag  = cfg_reg[gss_pkg::REG_L_DIAG];
    assign right_cfg.dead = cfg_reg[gss_pkg::REG_R_DEAD];
    assign right_cfg.axis = cfg_reg[gss_pkg::REG_R_AXIS];
    assign right_cfg.diag = cfg_reg[gss_pkg::REG_R_DIAG];

    // pipeline control: the whole pipe moves while its tail has somewhere to go
    logic  adv;
    logic  buf_ready;
    logic  vld_reg  [0:gss_pkg::NSTEP];
    trig_t trig_reg [0:gss_pkg::NSTEP];

    assign adv      = !vld_reg[gss_pkg::NSTEP] || buf_ready;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (adv)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            trig_reg[0].lt <= trig_shape(left_trigger_in, cfg_reg[gss_pkg::REG_LT_THR]);
            trig_reg[0].rt <= trig_shape(right_trigger_in, cfg_reg[gss_pkg::REG_RT_THR]);
        end
    end

    for (genvar k = 0; k < gss_pkg::NSTEP; k++)
    begin : g_side
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (adv)
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                trig_reg[k+1] <= trig_reg[k];
        end
    end

    // stick lanes
    gss_pkg::stick_out_t left_res;
    gss_pkg::stick_out_t right_res;

    gss_lane u_lane_left (
        .clk    (clk),
        .adv    (adv),
        .x_in   (left_x_in),
        .y_in   (left_y_in),
        .cfg    (left_cfg),
        .result (left_res)
    );

    gss_lane u_lane_right (
        .clk    (clk),
        .adv    (adv),
        .x_in   (right_x_in),
        .y_in   (right_y_in),
        .cfg    (right_cfg),
        .result (right_res)
    );

    // merge and output queue
    gss_pkg::report_t report;

    gss_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (adv && vld_reg[gss_pkg::NSTEP]),
        .left      (left_res),
        .right     (right_res),
        .lt        (trig_reg[gss_pkg::NSTEP].lt),
        .rt        (trig_reg[gss_pkg::NSTEP].rt),
        .ready     (buf_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .report    (report)
    );

    assign left_x_out        = $signed(report.left.x);
    assign left_y_out        = $signed(report.left.y);
    assign right_x_out       = $signed(report.right.x);
    assign right_y_out       = $signed(report.right.y);
    assign left_trigger_out  = $signed(report.lt);
    assign right_trigger_out = $signed(report.rt);

endmodule
